[sv/mcg_pkg.sv]
// ----------------------------------------------------------------------------
// mcg_pkg: shared constants and types for the mean-centered contrast gain
// Widths, operation codes and arithmetic constants used by the channel
// interfaces and the core.
// ----------------------------------------------------------------------------
package mcg_pkg;

	// Frame size limit and the widths that follow from it.
	localparam int MAX_PIXELS_LOG2 = 24;
	localparam int PIX_W           = 8;
	localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
	localparam int SUM_W           = MAX_PIXELS_LOG2 + PIX_W;
	localparam int PIXEL_LIMIT     = 1 << MAX_PIXELS_LOG2;

	// Contrast register and gain arithmetic.
	localparam int CONTRAST_W = 11;
	localparam int GAIN_W     = CONTRAST_W + 1;
	localparam int DIFF_W     = PIX_W + 1;
	localparam int PROD_W     = DIFF_W + GAIN_W;
	localparam int TOTAL_W    = PROD_W + 1;
	localparam int GAIN_BASE  = 100;

	// Scaled totals below SAT_TOTAL fit LOW_W bits; division by 100 is done
	// as a multiply by RECIP_100 and a right shift by RECIP_SHIFT.
	localparam int SAT_TOTAL   = 25600;
	localparam int LOW_W       = 15;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_W     = 28;
	localparam int RECIP_SHIFT = 19;
	localparam int PIX_MAX     = 255;

	// Mean divider: one quotient bit per step.
	localparam int DIV_STEPS = PIX_W;
	localparam int DIV_IDX_W = $clog2(DIV_STEPS);

	// Operation codes.
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_MAP     = 1'b1;

	// Accumulator record held in the state memory.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} acc_t;

endpackage

[sv/mcg_pixel_if.sv]
// ----------------------------------------------------------------------------
// mcg_pixel_if: input pixel channel
// Carries one operation code and one grey pixel per request.
// ----------------------------------------------------------------------------
interface mcg_pixel_if;

	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [mcg_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output operation, output pixel, input ready);
	modport sink   (input valid, input operation, input pixel, output ready);

endinterface

[sv/mcg_result_if.sv]
// ----------------------------------------------------------------------------
// mcg_result_if: mapped pixel channel
// Carries one contrast-adjusted pixel per request.
// ----------------------------------------------------------------------------
interface mcg_result_if;

	logic                     valid;
	logic                     ready;
	logic [mcg_pkg::PIX_W-1:0] mapped_pixel;

	modport source (output valid, output mapped_pixel, input ready);
	modport sink   (input valid, input mapped_pixel, output ready);

endinterface

[sv/mcg_cfg_if.sv]
// ----------------------------------------------------------------------------
// mcg_cfg_if: configuration write channel
// Carries the signed contrast percentage register value.
// ----------------------------------------------------------------------------
interface mcg_cfg_if;

	logic                          valid;
	logic                          ready;
	logic [mcg_pkg::CONTRAST_W-1:0] contrast_percent;

	modport source (output valid, output contrast_percent, input ready);
	modport sink   (input valid, input contrast_percent, output ready);

endinterface

[sv/mean_centered_contrast_gain.sv]
// Measure request: the read-modify-write step runs, then the next request can be taken.
// Map request: read-modify-write, map, sum, reciprocal and emit steps, then the next request;
// emit stalls until the output register is free. A pass's first map also runs the bit-serial mean divider.
// The single accumulator memory entry is read at acceptance and, for a measure, written back in the next cycle.
// Reset clears phase, mean, contrast and the accumulator valid bit; no clearing pass is run.
// ----------------------------------------------------------------------------
// mean_centered_contrast_gain: linear contrast stretch about the frame mean
// Measure requests accumulate pixel sum and count in a one-entry state
// memory; map requests scale each pixel's distance from the mean by
// (100 + contrast_percent) / 100 and clamp the result to 0..255.
// ----------------------------------------------------------------------------
module mean_centered_contrast_gain (
	input  logic         clk,
	input  logic         arst_n,
	mcg_pixel_if.sink    pixels,
	mcg_result_if.source results,
	mcg_cfg_if.sink      cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RMW,
		S_DIV,
		S_MAP,
		S_SUM,
		S_RECIP,
		S_EMIT
	} state_t;

	state_t state_q;

	// Control and architectural state.
	logic                                 phase_q;
	logic                                 acc_valid_q;
	logic [mcg_pkg::PIX_W-1:0]            mean_q;
	logic [mcg_pkg::CONTRAST_W-1:0]       contrast_q;
	logic [mcg_pkg::DIV_IDX_W-1:0]        div_idx_q;
	logic                                 out_valid_q;
	logic [mcg_pkg::PIX_W-1:0]            out_data_q;

	// Datapath registers.
	logic                                 op_q;
	logic [mcg_pkg::PIX_W-1:0]            pix_q;
	mcg_pkg::acc_t                        rd_q;
	logic [mcg_pkg::SUM_W-1:0]            rem_q;
	logic [mcg_pkg::CNT_W-1:0]            cnt_q;
	logic [mcg_pkg::PIX_W-1:0]            quo_q;
	logic signed [mcg_pkg::PROD_W-1:0]    prod_s1;
	logic signed [mcg_pkg::TOTAL_W-1:0]   total_s2;
	logic                                 neg_s3;
	logic                                 sat_s3;
	logic [mcg_pkg::RECIP_W-1:0]          recip_s3;

	// One-entry accumulator memory.
	mcg_pkg::acc_t                        acc_mem [1];

	logic                                 in_take;
	logic                                 mem_we;
	mcg_pkg::acc_t                        acc_base;
	mcg_pkg::acc_t                        acc_next;
	logic [mcg_pkg::SUM_W-1:0]            trial;
	logic                                 take;
	logic [mcg_pkg::SUM_W-1:0]            rem_next;
	logic [mcg_pkg::PIX_W-1:0]            quo_next;
	logic signed [mcg_pkg::DIFF_W-1:0]    diff;
	logic signed [mcg_pkg::GAIN_W-1:0]    gain;
	logic [mcg_pkg::LOW_W-1:0]            mean100;
	logic [mcg_pkg::PIX_W-1:0]            map_value;

	// Handshakes.
	assign pixels.ready         = (state_q == S_IDLE);
	assign in_take              = pixels.valid && pixels.ready;
	assign cfg.ready            = 1'b1;
	assign results.valid        = out_valid_q;
	assign results.mapped_pixel = out_data_q;

	// Accumulator update; a measure after a map pass restarts from zero.
	always_comb begin
		acc_base = (phase_q || !acc_valid_q) ? '0 : rd_q;
		acc_next = acc_base;
		if (acc_base.count < mcg_pkg::CNT_W'(mcg_pkg::PIXEL_LIMIT)) begin
			acc_next.sum   = acc_base.sum + mcg_pkg::SUM_W'(pix_q);
			acc_next.count = acc_base.count + mcg_pkg::CNT_W'(1);
		end
	end

	assign mem_we = (state_q == S_RMW) && (op_q == mcg_pkg::OP_MEASURE);

	// Restoring divider step, one quotient bit from the top down.
	assign trial    = mcg_pkg::SUM_W'(cnt_q) << div_idx_q;
	assign take     = (rem_q >= trial);
	assign rem_next = take ? (rem_q - trial) : rem_q;
	assign quo_next = {quo_q[mcg_pkg::PIX_W-2:0], take};

	// Gain arithmetic operands.
	assign diff      = signed'({1'b0, pix_q}) - signed'({1'b0, mean_q});
	assign gain      = mcg_pkg::GAIN_W'(mcg_pkg::GAIN_BASE) +
		signed'({contrast_q[mcg_pkg::CONTRAST_W-1], contrast_q});
	assign mean100   = mcg_pkg::LOW_W'(mean_q) * mcg_pkg::LOW_W'(mcg_pkg::GAIN_BASE);
	assign map_value = neg_s3 ? '0 :
		sat_s3 ? mcg_pkg::PIX_W'(mcg_pkg::PIX_MAX) :
		recip_s3[mcg_pkg::RECIP_SHIFT +: mcg_pkg::PIX_W];

	// State memory: registered read at acceptance, write-back in the following cycle for a measure.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			acc_mem[0] <= acc_next;
		end
		if (in_take) begin
			rd_q <= acc_mem[0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q  <= pixels.operation;
			pix_q <= pixels.pixel;
		end
		unique case (state_q)
			S_RMW: begin
				rem_q <= acc_base.sum;
				cnt_q <= acc_base.count;
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
			end
			S_MAP: begin
				prod_s1 <= mcg_pkg::PROD_W'(diff) * mcg_pkg::PROD_W'(gain);
			end
			S_SUM: begin
				total_s2 <= mcg_pkg::TOTAL_W'(prod_s1) +
					signed'(mcg_pkg::TOTAL_W'(mean100));
			end
			S_RECIP: begin
				neg_s3   <= total_s2[mcg_pkg::TOTAL_W-1];
				sat_s3   <= (total_s2 >= mcg_pkg::TOTAL_W'(mcg_pkg::SAT_TOTAL));
				recip_s3 <= mcg_pkg::RECIP_W'(total_s2[mcg_pkg::LOW_W-1:0]) *
					mcg_pkg::RECIP_W'(mcg_pkg::RECIP_100);
			end
			default: begin
			end
		endcase
	end

	// Sequencer with phase, mean, config and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			acc_valid_q <= 1'b0;
			mean_q      <= '0;
			contrast_q  <= '0;
			div_idx_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				contrast_q <= cfg.contrast_percent;
			end
			// The output register frees once taken; the emit step refills it.
			if (results.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					if (op_q == mcg_pkg::OP_MEASURE) begin
						acc_valid_q <= 1'b1;
						phase_q     <= 1'b0;
						state_q     <= S_IDLE;
					end else if (phase_q) begin
						state_q <= S_MAP;
					end else begin
						// First map of a pass latches the mean.
						phase_q <= 1'b1;
						if (acc_base.count == '0) begin
							mean_q  <= '0;
							state_q <= S_MAP;
						end else begin
							div_idx_q <= mcg_pkg::DIV_IDX_W'(mcg_pkg::DIV_STEPS - 1);
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_idx_q == '0) begin
						mean_q  <= quo_next;
						state_q <= S_MAP;
					end else begin
						div_idx_q <= div_idx_q - mcg_pkg::DIV_IDX_W'(1);
					end
				end
				S_MAP: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_RECIP;
				end
				S_RECIP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Hold the result until the output register is free.
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= map_value;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The stored pixel count never passes the frame limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (acc_next.count <= mcg_pkg::CNT_W'(mcg_pkg::PIXEL_LIMIT)))
		else $error("accumulator count beyond pixel limit");

	// The remainder stays below twice the current trial divisor, so the mean fits 8 bits.
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ({1'b0, rem_q} < ({1'b0, trial} << 1)))
		else $error("divider remainder out of range");

	// The divider only runs for a map request that opened the map phase.
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (phase_q && (op_q == mcg_pkg::OP_MAP)))
		else $error("divider running outside a map request");

	// A new result only appears after the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside the emit step");

endmodule
